>>> rtl/c_like_lexer_assert.svh
// Assertion macros shared by the lexer checker.
`ifndef C_LIKE_LEXER_ASSERT_SVH
`define C_LIKE_LEXER_ASSERT_SVH

// Check an expression at every clock edge outside reset.
`define CLL_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("lexer check failed");

// Check that an antecedent implies a consequent at the next clock edge.
`define CLL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lexer check failed");

`endif

>>> rtl/cll_pkg.sv
// Types, constants and byte classes for the C-like lexer.
`timescale 1ns / 1ps
`default_nettype none

package cll_pkg;

   localparam int POS_BITS_DEF = 16;
   localparam int QDEPTH       = 4;
   localparam int QPTR_BITS    = 2;
   localparam int QCNT_BITS    = 3;

   localparam logic [3:0] KIND_UNKNOWN = 4'd0;
   localparam logic [3:0] KIND_LPAREN  = 4'd1;
   localparam logic [3:0] KIND_RPAREN  = 4'd2;
   localparam logic [3:0] KIND_STAR    = 4'd3;
   localparam logic [3:0] KIND_COLON   = 4'd4;
   localparam logic [3:0] KIND_SEMI    = 4'd5;
   localparam logic [3:0] KIND_LBRACK  = 4'd6;
   localparam logic [3:0] KIND_RBRACK  = 4'd7;
   localparam logic [3:0] KIND_LBRACE  = 4'd8;
   localparam logic [3:0] KIND_RBRACE  = 4'd9;
   localparam logic [3:0] KIND_STRING  = 4'd10;
   localparam logic [3:0] KIND_IDENT   = 4'd11;
   localparam logic [3:0] KIND_END     = 4'd12;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   typedef enum logic [2:0] {
      MODE_IDLE       = 3'd0,
      MODE_SLASH      = 3'd1,
      MODE_LINE       = 3'd2,
      MODE_BLOCK      = 3'd3,
      MODE_BLOCK_STAR = 3'd4,
      MODE_STRING     = 3'd5,
      MODE_STRING_ESC = 3'd6,
      MODE_IDENT      = 3'd7
   } mode_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] start;
      logic [15:0] len;
      logic        last;
   } tok_type;

   typedef struct packed {
      tok_type    r0;
      tok_type    r1;
      logic [1:0] n;
   } scan_out_type;

   function automatic logic is_eol(input logic [7:0] c);
      return c inside {8'h0A, 8'h0D};
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0A, 8'h0D};
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
   endfunction

   function automatic logic is_ident_char(input logic [7:0] c);
      return c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], CH_UNDER};
   endfunction

   function automatic logic [3:0] punct_kind(input logic [7:0] c);
      logic [3:0] k;
      case (c)
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h2A:   k = KIND_STAR;
         8'h3A:   k = KIND_COLON;
         8'h3B:   k = KIND_SEMI;
         8'h5B:   k = KIND_LBRACK;
         8'h5D:   k = KIND_RBRACK;
         8'h7B:   k = KIND_LBRACE;
         8'h7D:   k = KIND_RBRACE;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

>>> rtl/cll_scan.sv
// Scanner: mode, position and token start registers with the per-byte token logic.
`timescale 1ns / 1ps
`default_nettype none

module cll_scan #(
   parameter int POS_BITS = cll_pkg::POS_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire logic [7:0]            ch,
   output cll_pkg::scan_out_type      res
);

   cll_pkg::mode_type     mode_ff, mode_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [POS_BITS-1:0]   start_ff, start_in;
   logic [POS_BITS-1:0]   pos_inc;
   logic [POS_BITS-1:0]   pend_len;

   cll_pkg::mode_type     idle_mode;
   logic                  idle_load;
   logic [POS_BITS-1:0]   idle_start;
   logic                  idle_emit;
   cll_pkg::tok_type      idle_tok;

   function automatic logic [15:0] clip(input logic [POS_BITS-1:0] v);
      logic [32:0] w;
      w = 33'(v);
      return (w > 33'(16'hFFFF)) ? 16'hFFFF : w[15:0];
   endfunction

   function automatic cll_pkg::tok_type mk(input logic [3:0] kind,
                                          input logic [15:0] start,
                                          input logic [15:0] len);
      cll_pkg::tok_type t;
      t.kind  = kind;
      t.start = start;
      t.len   = len;
      t.last  = 1'b0;
      return t;
   endfunction

   assign pos_inc  = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;
   assign pend_len = (pos_ff > start_ff) ? pos_ff - start_ff : '0;

   always_comb begin
      idle_mode  = cll_pkg::MODE_IDLE;
      idle_load  = 1'b0;
      idle_start = pos_ff;
      idle_emit  = 1'b0;
      idle_tok   = mk(cll_pkg::punct_kind(ch), clip(pos_ff), 16'd1);
      if (cll_pkg::is_space(ch)) begin
         idle_mode = cll_pkg::MODE_IDLE;
      end else if (ch == cll_pkg::CH_SLASH) begin
         idle_mode = cll_pkg::MODE_SLASH;
         idle_load = 1'b1;
      end else if (ch == cll_pkg::CH_QUOTE) begin
         idle_mode  = cll_pkg::MODE_STRING;
         idle_load  = 1'b1;
         idle_start = pos_inc;
      end else if (cll_pkg::is_letter(ch)) begin
         idle_mode = cll_pkg::MODE_IDENT;
         idle_load = 1'b1;
      end else begin
         idle_emit = 1'b1;
      end
   end

   // next state
   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      pos_in   = pos_inc;
      if (ch == cll_pkg::CH_NUL) begin
         mode_in  = cll_pkg::MODE_IDLE;
         start_in = '0;
         pos_in   = '0;
      end else begin
         case (mode_ff)
            cll_pkg::MODE_SLASH: begin
               if (ch == cll_pkg::CH_SLASH) begin
                  mode_in = cll_pkg::MODE_LINE;
               end else if (ch == cll_pkg::CH_STAR) begin
                  mode_in = cll_pkg::MODE_BLOCK;
               end else begin
                  mode_in = idle_mode;
                  if (idle_load) start_in = idle_start;
               end
            end
            cll_pkg::MODE_LINE: begin
               if (cll_pkg::is_eol(ch)) mode_in = cll_pkg::MODE_IDLE;
            end
            cll_pkg::MODE_BLOCK: begin
               if (ch == cll_pkg::CH_STAR) mode_in = cll_pkg::MODE_BLOCK_STAR;
            end
            cll_pkg::MODE_BLOCK_STAR: begin
               if (ch == cll_pkg::CH_SLASH) mode_in = cll_pkg::MODE_IDLE;
               else if (ch != cll_pkg::CH_STAR) mode_in = cll_pkg::MODE_BLOCK;
            end
            cll_pkg::MODE_STRING: begin
               if (ch == cll_pkg::CH_QUOTE) mode_in = cll_pkg::MODE_IDLE;
               else if (ch == cll_pkg::CH_BSLASH) mode_in = cll_pkg::MODE_STRING_ESC;
            end
            cll_pkg::MODE_STRING_ESC: begin
               mode_in = cll_pkg::MODE_STRING;
            end
            cll_pkg::MODE_IDENT: begin
               if (!cll_pkg::is_ident_char(ch)) begin
                  mode_in = idle_mode;
                  if (idle_load) start_in = idle_start;
               end
            end
            default: begin
               mode_in = idle_mode;
               if (idle_load) start_in = idle_start;
            end
         endcase
      end
   end

   // token outputs
   always_comb begin
      logic             a_v;
      logic             b_v;
      cll_pkg::tok_type a_tok;
      cll_pkg::tok_type b_tok;
      a_v   = 1'b0;
      b_v   = 1'b0;
      a_tok = mk(cll_pkg::KIND_UNKNOWN, clip(start_ff), 16'd1);
      b_tok = idle_tok;
      if (ch == cll_pkg::CH_NUL) begin
         b_v   = 1'b1;
         b_tok = mk(cll_pkg::KIND_END, clip(pos_ff), 16'd1);
         case (mode_ff)
            cll_pkg::MODE_IDENT: begin
               a_v   = 1'b1;
               a_tok = mk(cll_pkg::KIND_IDENT, clip(start_ff), clip(pend_len));
            end
            cll_pkg::MODE_STRING, cll_pkg::MODE_STRING_ESC: begin
               a_v   = 1'b1;
               a_tok = mk(cll_pkg::KIND_STRING, clip(start_ff), clip(pend_len));
            end
            cll_pkg::MODE_SLASH: begin
               a_v = 1'b1;
            end
            default: begin
               a_v = 1'b0;
            end
         endcase
      end else begin
         case (mode_ff)
            cll_pkg::MODE_SLASH: begin
               if (ch != cll_pkg::CH_SLASH && ch != cll_pkg::CH_STAR) begin
                  a_v = 1'b1;
                  b_v = idle_emit;
               end
            end
            cll_pkg::MODE_STRING: begin
               if (ch == cll_pkg::CH_QUOTE) begin
                  a_v   = 1'b1;
                  a_tok = mk(cll_pkg::KIND_STRING, clip(start_ff), clip(pend_len));
               end
            end
            cll_pkg::MODE_IDENT: begin
               if (!cll_pkg::is_ident_char(ch)) begin
                  a_v   = 1'b1;
                  a_tok = mk(cll_pkg::KIND_IDENT, clip(start_ff), clip(pend_len));
                  b_v   = idle_emit;
               end
            end
            cll_pkg::MODE_IDLE: begin
               b_v = idle_emit;
            end
            default: begin
               b_v = 1'b0;
            end
         endcase
      end
      if (a_v) begin
         res.r0 = a_tok;
         res.r1 = b_tok;
         res.n  = b_v ? 2'd2 : 2'd1;
      end else begin
         res.r0 = b_tok;
         res.r1 = b_tok;
         res.n  = b_v ? 2'd1 : 2'd0;
      end
      res.r0.last = (res.n == 2'd1);
      res.r1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= cll_pkg::MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/c_like_lexer.sv
// A byte accepted into the input register is scanned and its tokens are written into the
// result queue once the queue has room for two tokens; rsp_ then shows the queue head.
// Throughput: one byte per cycle while the queue has room for two tokens, as a new byte is
// taken as the held one is scanned; the queue drains one token per cycle while rsp_ready is high.
// Reset (synchronous): clears scan mode, position, token start and the result queue.
// Top level of the C-like lexer: input register, scanner and result queue.
`timescale 1ns / 1ps
`default_nettype none

module c_like_lexer #(
   parameter int POS_BITS = cll_pkg::POS_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_ch,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_token_kind,
   output logic [15:0]      rsp_start_offset,
   output logic [15:0]      rsp_text_length,
   output logic             rsp_last
);

   logic                           in_valid_ff, in_valid_in;
   logic [7:0]                     ch_ff;
   logic                           fire;
   logic                           pop;
   cll_pkg::scan_out_type          res;
   cll_pkg::tok_type               q_ff [cll_pkg::QDEPTH];
   logic [cll_pkg::QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [cll_pkg::QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [cll_pkg::QCNT_BITS-1:0]  count_ff, count_in;
   cll_pkg::tok_type               head;

   cll_scan #(
      .POS_BITS (POS_BITS)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .ch    (ch_ff),
      .res   (res)
   );

   // scan only with room for two tokens
   assign fire      = in_valid_ff && (count_ff <= cll_pkg::QCNT_BITS'(cll_pkg::QDEPTH - 2));
   assign req_ready = !in_valid_ff || fire;
   assign pop       = rsp_valid && rsp_ready;

   assign in_valid_in = (req_valid && req_ready) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign wr_ptr_in   = fire ? wr_ptr_ff + cll_pkg::QPTR_BITS'(res.n) : wr_ptr_ff;
   assign rd_ptr_in   = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in    = count_ff + (fire ? cll_pkg::QCNT_BITS'(res.n) : '0)
                        - cll_pkg::QCNT_BITS'(pop);

   assign head             = q_ff[rd_ptr_ff];
   assign rsp_valid        = (count_ff != '0);
   assign rsp_token_kind   = head.kind;
   assign rsp_start_offset = head.start;
   assign rsp_text_length  = head.len;
   assign rsp_last         = head.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) ch_ff <= req_ch;
      if (fire && res.n != 2'd0) q_ff[wr_ptr_ff] <= res.r0;
      if (fire && res.n == 2'd2) q_ff[wr_ptr_ff + 1'b1] <= res.r1;
   end

endmodule

`default_nettype wire

>>> rtl/cll_checker.sv
// Port-level checker for the C-like lexer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "c_like_lexer_assert.svh"

module cll_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  rsp_token_kind,
   input wire logic [15:0] rsp_start_offset,
   input wire logic [15:0] rsp_text_length,
   input wire logic        rsp_last
);

   logic        end_beat;
   logic        punct_beat;
   logic [36:0] rsp_beat;

   assign end_beat   = rsp_valid && (rsp_token_kind == cll_pkg::KIND_END);
   assign punct_beat = rsp_valid
                       && (rsp_token_kind inside {[cll_pkg::KIND_LPAREN:cll_pkg::KIND_RBRACE]});
   assign rsp_beat   = {rsp_token_kind, rsp_start_offset, rsp_text_length, rsp_last};

   `CLL_ASSERT_ALWAYS(a_kind_range, !rsp_valid || rsp_token_kind <= cll_pkg::KIND_END)
   `CLL_ASSERT_ALWAYS(a_end_beat, !end_beat || (rsp_last && rsp_text_length == 16'd1))
   `CLL_ASSERT_ALWAYS(a_punct_len, !punct_beat || rsp_text_length == 16'd1)
   `CLL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_beat))

endmodule

bind c_like_lexer cll_checker u_cll_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_token_kind   (rsp_token_kind),
   .rsp_start_offset (rsp_start_offset),
   .rsp_text_length  (rsp_text_length),
   .rsp_last         (rsp_last)
);

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking testbench for the c_like_lexer byte tokenizer, with its own token predictor.
`timescale 1ns / 1ps

module tb_top;

   localparam int STALL_LIMIT = 1000;
   localparam int ITEMS_PER_MIX = 270;

   typedef struct packed {
      logic [7:0]  ch;
      logic        typed;
      logic [3:0]  kind;
      logic [15:0] start;
   } lex_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_ch = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_token_kind;
   logic [15:0] rsp_start_offset;
   logic [15:0] rsp_text_length;
   logic        rsp_last;

   // sideband that travels with each byte: a typed-in token for directed rows
   logic             row_typed = 1'b0;
   cll_pkg::tok_type row_want = '0;

   cll_pkg::mode_type lex_mode = cll_pkg::MODE_IDLE;
   logic [15:0]       lex_pos = 16'd0;
   logic [15:0]       tok_begin = 16'd0;
   cll_pkg::tok_type  step_toks[$];
   cll_pkg::tok_type  expected_tokens[$];
   cll_pkg::tok_type  want_tok;
   cll_pkg::tok_type  got_tok;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int random_items = 0;
   int bytes_scanned = 0;
   int tokens_checked = 0;
   int fault_count = 0;
   int idle_cycles = 0;
   string punct_set = "()*:;[]{}";

   lex_row_type script[$] = '{
      '{"(",                1'b1, cll_pkg::KIND_LPAREN,  16'd0},
      '{"a",                1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{"9",                1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_UNDER,  1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{")",                1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_STAR,   1'b1, cll_pkg::KIND_STAR,    16'd5},
      '{cll_pkg::CH_SLASH,  1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{":",                1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_QUOTE,  1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_BSLASH, 1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_QUOTE,  1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_QUOTE,  1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_SLASH,  1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_STAR,   1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_SLASH,  1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_STAR,   1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_SLASH,  1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{8'hFF,              1'b1, cll_pkg::KIND_UNKNOWN, 16'd17},
      '{"Q",                1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{"]",                1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_NUL,    1'b1, cll_pkg::KIND_END,     16'd20},
      '{cll_pkg::CH_QUOTE,  1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_BSLASH, 1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_NUL,    1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_SLASH,  1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_NUL,    1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_SLASH,  1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_STAR,   1'b0, cll_pkg::KIND_UNKNOWN, 16'd0},
      '{cll_pkg::CH_NUL,    1'b1, cll_pkg::KIND_END,     16'd2}
   };

   c_like_lexer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ch           (req_ch),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_start_offset (rsp_start_offset),
      .rsp_text_length  (rsp_text_length),
      .rsp_last         (rsp_last)
   );

   always #1 clock = ~clock;

   function automatic logic ends_line(input logic [7:0] c);
      return c == 8'h0A || c == 8'h0D;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C || ends_line(c);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic [3:0] punct_of(input logic [7:0] c);
      logic [3:0] k;
      case (c)
         "(":     k = cll_pkg::KIND_LPAREN;
         ")":     k = cll_pkg::KIND_RPAREN;
         "*":     k = cll_pkg::KIND_STAR;
         ":":     k = cll_pkg::KIND_COLON;
         ";":     k = cll_pkg::KIND_SEMI;
         "[":     k = cll_pkg::KIND_LBRACK;
         "]":     k = cll_pkg::KIND_RBRACK;
         "{":     k = cll_pkg::KIND_LBRACE;
         "}":     k = cll_pkg::KIND_RBRACE;
         default: k = cll_pkg::KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic logic [15:0] bump(input logic [15:0] p);
      return (p == 16'hFFFF) ? p : p + 16'd1;
   endfunction

   function automatic logic [15:0] span_len();
      return (lex_pos > tok_begin) ? lex_pos - tok_begin : 16'd0;
   endfunction

   function automatic void add_token(input logic [3:0] k, input logic [15:0] s,
                                     input logic [15:0] l);
      cll_pkg::tok_type t;
      t.kind = k;
      t.start = s;
      t.len = l;
      t.last = 1'b0;
      step_toks.push_back(t);
   endfunction

   function automatic void start_from_idle(input logic [7:0] c);
      lex_mode = cll_pkg::MODE_IDLE;
      if (is_blank(c)) begin
         lex_mode = cll_pkg::MODE_IDLE;
      end else if (c == cll_pkg::CH_SLASH) begin
         lex_mode = cll_pkg::MODE_SLASH;
         tok_begin = lex_pos;
      end else if (c == cll_pkg::CH_QUOTE) begin
         lex_mode = cll_pkg::MODE_STRING;
         tok_begin = bump(lex_pos);
      end else if (is_alpha(c)) begin
         lex_mode = cll_pkg::MODE_IDENT;
         tok_begin = lex_pos;
      end else begin
         add_token(punct_of(c), lex_pos, 16'd1);
      end
   endfunction

   // advance the token scanner by one byte, leaving its tokens in step_toks
   task automatic scan_byte(input logic [7:0] c);
      cll_pkg::tok_type tail;
      step_toks.delete();
      if (c == cll_pkg::CH_NUL) begin
         case (lex_mode)
            cll_pkg::MODE_IDENT: add_token(cll_pkg::KIND_IDENT, tok_begin, span_len());
            cll_pkg::MODE_STRING, cll_pkg::MODE_STRING_ESC:
               add_token(cll_pkg::KIND_STRING, tok_begin, span_len());
            cll_pkg::MODE_SLASH: add_token(cll_pkg::KIND_UNKNOWN, tok_begin, 16'd1);
            default: ;
         endcase
         add_token(cll_pkg::KIND_END, lex_pos, 16'd1);
         lex_mode = cll_pkg::MODE_IDLE;
         lex_pos = 16'd0;
         tok_begin = 16'd0;
      end else begin
         case (lex_mode)
            cll_pkg::MODE_SLASH: begin
               if (c == cll_pkg::CH_SLASH) begin
                  lex_mode = cll_pkg::MODE_LINE;
               end else if (c == cll_pkg::CH_STAR) begin
                  lex_mode = cll_pkg::MODE_BLOCK;
               end else begin
                  add_token(cll_pkg::KIND_UNKNOWN, tok_begin, 16'd1);
                  start_from_idle(c);
               end
            end
            cll_pkg::MODE_LINE: begin
               if (ends_line(c)) lex_mode = cll_pkg::MODE_IDLE;
            end
            cll_pkg::MODE_BLOCK: begin
               if (c == cll_pkg::CH_STAR) lex_mode = cll_pkg::MODE_BLOCK_STAR;
            end
            cll_pkg::MODE_BLOCK_STAR: begin
               if (c == cll_pkg::CH_SLASH) lex_mode = cll_pkg::MODE_IDLE;
               else if (c != cll_pkg::CH_STAR) lex_mode = cll_pkg::MODE_BLOCK;
            end
            cll_pkg::MODE_STRING: begin
               if (c == cll_pkg::CH_QUOTE) begin
                  add_token(cll_pkg::KIND_STRING, tok_begin, span_len());
                  lex_mode = cll_pkg::MODE_IDLE;
               end else if (c == cll_pkg::CH_BSLASH) begin
                  lex_mode = cll_pkg::MODE_STRING_ESC;
               end
            end
            cll_pkg::MODE_STRING_ESC: lex_mode = cll_pkg::MODE_STRING;
            cll_pkg::MODE_IDENT: begin
               if (!(is_alpha(c) || (c >= "0" && c <= "9") || c == cll_pkg::CH_UNDER)) begin
                  add_token(cll_pkg::KIND_IDENT, tok_begin, span_len());
                  start_from_idle(c);
               end
            end
            default: start_from_idle(c);
         endcase
         lex_pos = bump(lex_pos);
      end
      if (step_toks.size() != 0) begin
         tail = step_toks.pop_back();
         tail.last = 1'b1;
         step_toks.push_back(tail);
      end
   endtask

   task automatic flag_fault(input string what, input cll_pkg::tok_type want,
                             input cll_pkg::tok_type got);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%s: expected kind %0d start %0d len %0d last %0b",
                  what, want.kind, want.start, want.len, want.last);
         $display("   got kind %0d start %0d len %0d last %0b",
                  got.kind, got.start, got.len, got.last);
      end
   endtask

   // hold the byte until the beat is taken
   task automatic send_byte(input logic [7:0] c, input logic typed = 1'b0,
                            input logic [3:0] kind = cll_pkg::KIND_UNKNOWN,
                            input logic [15:0] start = 16'd0);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      row_typed <= typed;
      row_want <= '{kind, start, 16'd1, 1'b1};
      random_items++;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop in an end-of-stream byte now and then to cut the sequence short
   task automatic send_or_cut(input logic [7:0] c, inout logic cut);
      if (!cut) begin
         if ($urandom_range(0, 99) < 3) begin
            send_byte(cll_pkg::CH_NUL);
            cut = 1'b1;
         end else begin
            send_byte(c);
         end
      end
   endtask

   function automatic logic [7:0] pick_letter();
      return ($urandom_range(0, 1) != 0) ? 8'($urandom_range("a", "z"))
                                         : 8'($urandom_range("A", "Z"));
   endfunction

   task automatic send_chunk();
      int pick;
      int len;
      logic cut;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      len = $urandom_range(0, 8);
      cut = 1'b0;
      if (pick < 12) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 5))
               0: b = " ";
               1: b = 8'h09;
               2: b = 8'h0B;
               3: b = 8'h0C;
               4: b = 8'h0A;
               default: b = 8'h0D;
            endcase
            send_byte(b);
         end
      end else if (pick < 30) begin
         send_byte(punct_set[$urandom_range(0, 8)]);
      end else if (pick < 50) begin
         send_byte(pick_letter());
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 3))
               0: b = 8'($urandom_range("0", "9"));
               1: b = cll_pkg::CH_UNDER;
               default: b = pick_letter();
            endcase
            send_or_cut(b, cut);
         end
      end else if (pick < 63) begin
         send_byte(cll_pkg::CH_QUOTE);
         for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(1, 255));
            if (b == cll_pkg::CH_QUOTE) b = cll_pkg::CH_BSLASH;
            send_or_cut(b, cut);
         end
         send_or_cut(cll_pkg::CH_QUOTE, cut);
      end else if (pick < 70) begin
         send_byte(cll_pkg::CH_SLASH);
         send_byte(cll_pkg::CH_SLASH);
         for (int i = 0; i < len; i++) send_or_cut(8'($urandom_range(1, 255)), cut);
         send_or_cut(($urandom_range(0, 1) != 0) ? 8'h0A : 8'h0D, cut);
      end else if (pick < 79) begin
         send_byte(cll_pkg::CH_SLASH);
         send_byte(cll_pkg::CH_STAR);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 3))
               0: b = cll_pkg::CH_STAR;
               1: b = cll_pkg::CH_SLASH;
               default: b = 8'($urandom_range(1, 255));
            endcase
            send_or_cut(b, cut);
         end
         send_or_cut(cll_pkg::CH_STAR, cut);
         send_or_cut(cll_pkg::CH_SLASH, cut);
      end else if (pick < 86) begin
         send_byte(cll_pkg::CH_SLASH);
      end else if (pick < 96) begin
         send_byte(8'($urandom_range(1, 255)));
      end else begin
         send_byte(cll_pkg::CH_NUL);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lex_mode = cll_pkg::MODE_IDLE;
         lex_pos = 16'd0;
         tok_begin = 16'd0;
      end else if (req_valid && req_ready) begin
         bytes_scanned++;
         scan_byte(req_ch);
         if (row_typed) begin
            expected_tokens.push_back(row_want);
         end else begin
            foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         got_tok = '{rsp_token_kind, rsp_start_offset, rsp_text_length, rsp_last};
         if (expected_tokens.size() == 0) begin
            flag_fault("unexpected token", '0, got_tok);
         end else begin
            want_tok = expected_tokens.pop_front();
            tokens_checked++;
            if (got_tok !== want_tok) flag_fault("token mismatch", want_tok, got_tok);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("No beat moved for %0d cycles", STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 30;
      recv_idle_pct = 57;
      foreach (script[i])
         send_byte(script[i].ch, script[i].typed, script[i].kind, script[i].start);

      for (int mix = 0; mix < 3; mix++) begin
         send_idle_pct = (mix == 0) ? 30 : (mix == 1) ? 57 : 0;
         recv_idle_pct = (mix == 0) ? 57 : (mix == 1) ? 30 : 0;
         random_items = 0;
         while (random_items < ITEMS_PER_MIX) send_chunk();
      end
      req_valid <= 1'b0;

      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Scanned %0d bytes and matched %0d tokens under three pacing mixes,",
               bytes_scanned, tokens_checked);
      $display("after a directed walk through each token kind and end-of-stream flush.");
      if (fault_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
